>>> src/decimal128_compare_assert.svh
// ----------------------------------------------------------------------------
// Decimal compare assertion macros
// Concurrent assertion wrappers shared by the decimal compare design. They
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL128_COMPARE_ASSERT_SVH
`define DECIMAL128_COMPARE_ASSERT_SVH

`ifndef SYNTHESIS
`define DCMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DCMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCMP_ASSERT(lbl, prop, msg)
`define DCMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/dcmp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal compare package
// Shared widths, result codes, the stage control group and the table of
// powers of ten.
// ----------------------------------------------------------------------------
package dcmp_pkg;

  localparam int SCALE_W        = 5;
  localparam int LO_W           = 64;
  localparam int HI_W           = 32;
  localparam int FULL_W         = LO_W + HI_W;
  localparam int LIMB_W         = 32;
  localparam int PROD_W         = 2 * LIMB_W;
  localparam int POW_TAB_W      = 128;
  localparam int MAX_SCALE_DEF  = 28;
  localparam int MANTISSA_W_DEF = 96;

  typedef enum logic [1:0] {
    ORDER_LESS    = 2'd0,
    ORDER_EQUAL   = 2'd1,
    ORDER_GREATER = 2'd2
  } order_t;

  // Decisions taken at the front that ride along with the magnitudes.
  typedef struct packed {
    logic   early;        // result already known from zeros or signs
    order_t early_order;
    logic   swapped;      // scaled operand is the second one
    logic   invert;       // first operand negative (both are, unless early)
  } ctl_t;

  function automatic logic [POW_TAB_W-1:0] pow10(input logic [SCALE_W-1:0] d);
    logic [POW_TAB_W-1:0] v;
    unique case (d)
      5'd0:  v = 128'd1;
      5'd1:  v = 128'd10;
      5'd2:  v = 128'd100;
      5'd3:  v = 128'd1000;
      5'd4:  v = 128'd10000;
      5'd5:  v = 128'd100000;
      5'd6:  v = 128'd1000000;
      5'd7:  v = 128'd10000000;
      5'd8:  v = 128'd100000000;
      5'd9:  v = 128'd1000000000;
      5'd10: v = 128'd10000000000;
      5'd11: v = 128'd100000000000;
      5'd12: v = 128'd1000000000000;
      5'd13: v = 128'd10000000000000;
      5'd14: v = 128'd100000000000000;
      5'd15: v = 128'd1000000000000000;
      5'd16: v = 128'd10000000000000000;
      5'd17: v = 128'd100000000000000000;
      5'd18: v = 128'd1000000000000000000;
      5'd19: v = 128'd10000000000000000000;
      5'd20: v = 128'd100000000000000000000;
      5'd21: v = 128'd1000000000000000000000;
      5'd22: v = 128'd10000000000000000000000;
      5'd23: v = 128'd100000000000000000000000;
      5'd24: v = 128'd1000000000000000000000000;
      5'd25: v = 128'd10000000000000000000000000;
      5'd26: v = 128'd100000000000000000000000000;
      5'd27: v = 128'd1000000000000000000000000000;
      5'd28: v = 128'd10000000000000000000000000000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Number of bits needed to hold ten to the given power.
  function automatic int pow10_bits(input int n);
    logic [POW_TAB_W-1:0] v;
    int w;
    v = pow10(SCALE_W'(n));
    w = 1;
    for (int i = 0; i < POW_TAB_W; i++) begin
      if (v[i]) begin
        w = i + 1;
      end
    end
    return w;
  endfunction

  function automatic int limbs(input int bits);
    return (bits + LIMB_W - 1) / LIMB_W;
  endfunction

endpackage

>>> src/dcmp_if.sv
// ----------------------------------------------------------------------------
// Decimal compare channels
// Valid/ready channels for the operand pair and for the comparison result.
// ----------------------------------------------------------------------------
interface dcmp_in_if;
  logic                        valid;
  logic                        ready;
  logic [dcmp_pkg::LO_W-1:0]    a_mantissa_low;
  logic [dcmp_pkg::HI_W-1:0]    a_mantissa_high;
  logic [dcmp_pkg::SCALE_W-1:0] a_scale;
  logic                        a_negative;
  logic [dcmp_pkg::LO_W-1:0]    b_mantissa_low;
  logic [dcmp_pkg::HI_W-1:0]    b_mantissa_high;
  logic [dcmp_pkg::SCALE_W-1:0] b_scale;
  logic                        b_negative;

  modport source (
    output valid, a_mantissa_low, a_mantissa_high, a_scale, a_negative,
           b_mantissa_low, b_mantissa_high, b_scale, b_negative,
    input  ready
  );
  modport sink (
    input  valid, a_mantissa_low, a_mantissa_high, a_scale, a_negative,
           b_mantissa_low, b_mantissa_high, b_scale, b_negative,
    output ready
  );
endinterface

interface dcmp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] order;

  modport source (output valid, order, input ready);
  modport sink (input valid, order, output ready);
endinterface

>>> src/decimal128_compare.sv
// ----------------------------------------------------------------------------
// Decimal128 compare
// Accepted operand pairs pass through the stages below in order to the port.
// Throughput: one item per cycle while result.ready holds; the stages are front
// decode, partial products, row sums, full product and the compare/output register.
// Each stage holds its item only while the next is full, so bubbles close up.
// Reset (synchronous) empties every stage; the data registers are not reset.
// ----------------------------------------------------------------------------
`include "decimal128_compare_assert.svh"

module decimal128_compare #(
  parameter int MAX_SCALE      = dcmp_pkg::MAX_SCALE_DEF,
  parameter int MANTISSA_WIDTH = dcmp_pkg::MANTISSA_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dcmp_in_if.sink     operands,
  dcmp_out_if.source  result
);

  localparam int PW = dcmp_pkg::pow10_bits(MAX_SCALE);
  localparam int TW = dcmp_pkg::LIMB_W * (dcmp_pkg::limbs(MANTISSA_WIDTH)
                      + dcmp_pkg::limbs(PW));

  logic                      align_valid, align_ready;
  dcmp_pkg::ctl_t            align_ctl;
  logic [MANTISSA_WIDTH-1:0] align_x, align_y;
  logic [PW-1:0]             align_power;

  logic                      mul_valid, mul_ready;
  dcmp_pkg::ctl_t            mul_ctl;
  logic [MANTISSA_WIDTH-1:0] mul_y;
  logic [TW-1:0]             mul_total;

  dcmp_pkg::order_t          order;

  dcmp_align #(
    .MAX_SCALE      (MAX_SCALE),
    .MANTISSA_WIDTH (MANTISSA_WIDTH)
  ) u_align (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (operands.valid),
    .in_ready        (operands.ready),
    .a_mantissa_low  (operands.a_mantissa_low),
    .a_mantissa_high (operands.a_mantissa_high),
    .a_scale         (operands.a_scale),
    .a_negative      (operands.a_negative),
    .b_mantissa_low  (operands.b_mantissa_low),
    .b_mantissa_high (operands.b_mantissa_high),
    .b_scale         (operands.b_scale),
    .b_negative      (operands.b_negative),
    .out_valid       (align_valid),
    .out_ready       (align_ready),
    .ctl             (align_ctl),
    .x               (align_x),
    .y               (align_y),
    .power           (align_power)
  );

  dcmp_mul #(
    .MAX_SCALE      (MAX_SCALE),
    .MANTISSA_WIDTH (MANTISSA_WIDTH)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (align_valid),
    .in_ready  (align_ready),
    .ctl_in    (align_ctl),
    .x         (align_x),
    .y_in      (align_y),
    .power     (align_power),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .ctl_out   (mul_ctl),
    .y_out     (mul_y),
    .total     (mul_total)
  );

  dcmp_order #(
    .MAX_SCALE      (MAX_SCALE),
    .MANTISSA_WIDTH (MANTISSA_WIDTH)
  ) u_order (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .ctl       (mul_ctl),
    .y         (mul_y),
    .total     (mul_total),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .order     (order)
  );

  assign result.order = order;

  // An accepted item always lands in the front stage.
  `DCMP_ASSERT(a_accept_loads, operands.valid && operands.ready |=> align_valid, "accepted item lost at front stage")
  // A new result can only come from an item waiting in the multiplier.
  `DCMP_ASSERT(a_result_source, $rose(result.valid) |-> $past(mul_valid), "result appeared without a source item")
  // The operand with the smaller scale is always scaled by at least ten.
  `DCMP_ASSERT(a_power_scaled, align_valid && !align_ctl.swapped |-> align_power != PW'(1), "scale choice and power disagree")
  `DCMP_ASSERT_ALWAYS(a_reset_clears, rst |=> !result.valid, "result valid after reset")

endmodule

>>> src/dcmp_align.sv
// ----------------------------------------------------------------------------
// Decimal compare front stage
// Masks the mantissas, saturates the scales, settles zero and sign cases and
// picks the operand to scale together with its power of ten.
// ----------------------------------------------------------------------------
module dcmp_align #(
  parameter int MAX_SCALE      = dcmp_pkg::MAX_SCALE_DEF,
  parameter int MANTISSA_WIDTH = dcmp_pkg::MANTISSA_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dcmp_pkg::LO_W-1:0]    a_mantissa_low,
  input  logic [dcmp_pkg::HI_W-1:0]    a_mantissa_high,
  input  logic [dcmp_pkg::SCALE_W-1:0] a_scale,
  input  logic                         a_negative,
  input  logic [dcmp_pkg::LO_W-1:0]    b_mantissa_low,
  input  logic [dcmp_pkg::HI_W-1:0]    b_mantissa_high,
  input  logic [dcmp_pkg::SCALE_W-1:0] b_scale,
  input  logic                         b_negative,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dcmp_pkg::ctl_t               ctl,
  output logic [MANTISSA_WIDTH-1:0]    x,
  output logic [MANTISSA_WIDTH-1:0]    y,
  output logic [dcmp_pkg::pow10_bits(MAX_SCALE)-1:0] power
);

  localparam int MW = MANTISSA_WIDTH;
  localparam int PW = dcmp_pkg::pow10_bits(MAX_SCALE);
  localparam logic [dcmp_pkg::SCALE_W-1:0] SCALE_TOP = dcmp_pkg::SCALE_W'(MAX_SCALE);

  logic                              valid;
  logic [dcmp_pkg::FULL_W-1:0]       a_full, b_full;
  logic [MW-1:0]                     a_m, b_m;
  logic [dcmp_pkg::SCALE_W-1:0]      sa, sb, diff;
  logic                              a_first;
  logic [dcmp_pkg::POW_TAB_W-1:0]    pow_full;
  logic                              both_zero;
  dcmp_pkg::ctl_t                    ctl_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    a_full    = {a_mantissa_high, a_mantissa_low};
    b_full    = {b_mantissa_high, b_mantissa_low};
    a_m       = a_full[MW-1:0];
    b_m       = b_full[MW-1:0];
    sa        = (a_scale > SCALE_TOP) ? SCALE_TOP : a_scale;
    sb        = (b_scale > SCALE_TOP) ? SCALE_TOP : b_scale;
    a_first   = sa < sb;
    diff      = a_first ? (sb - sa) : (sa - sb);
    pow_full  = dcmp_pkg::pow10(diff);
    both_zero = (a_m == '0) && (b_m == '0);

    ctl_next.early   = both_zero || (a_negative != b_negative);
    if (both_zero) begin
      ctl_next.early_order = dcmp_pkg::ORDER_EQUAL;
    end else if (a_negative) begin
      ctl_next.early_order = dcmp_pkg::ORDER_LESS;
    end else begin
      ctl_next.early_order = dcmp_pkg::ORDER_GREATER;
    end
    ctl_next.swapped = !a_first;
    ctl_next.invert  = a_negative;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ctl   <= ctl_next;
      x     <= a_first ? a_m : b_m;
      y     <= a_first ? b_m : a_m;
      power <= pow_full[PW-1:0];
    end
  end

endmodule

>>> src/dcmp_mul.sv
// ----------------------------------------------------------------------------
// Decimal compare scaling multiplier
// Three stages: limb partial products, row sums, and the full exact product
// of the mantissa and its power of ten.
// ----------------------------------------------------------------------------
module dcmp_mul #(
  parameter int MAX_SCALE      = dcmp_pkg::MAX_SCALE_DEF,
  parameter int MANTISSA_WIDTH = dcmp_pkg::MANTISSA_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dcmp_pkg::ctl_t            ctl_in,
  input  logic [MANTISSA_WIDTH-1:0] x,
  input  logic [MANTISSA_WIDTH-1:0] y_in,
  input  logic [dcmp_pkg::pow10_bits(MAX_SCALE)-1:0] power,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dcmp_pkg::ctl_t            ctl_out,
  output logic [MANTISSA_WIDTH-1:0] y_out,
  output logic [dcmp_pkg::LIMB_W*(dcmp_pkg::limbs(MANTISSA_WIDTH)
                + dcmp_pkg::limbs(dcmp_pkg::pow10_bits(MAX_SCALE)))-1:0] total
);

  localparam int LW = dcmp_pkg::LIMB_W;
  localparam int MW = MANTISSA_WIDTH;
  localparam int PW = dcmp_pkg::pow10_bits(MAX_SCALE);
  localparam int ML = dcmp_pkg::limbs(MW);
  localparam int PL = dcmp_pkg::limbs(PW);
  localparam int RW = LW * (PL + 1);
  localparam int TW = LW * (ML + PL);

  logic [LW*ML-1:0]              x_pad;
  logic [LW*PL-1:0]              p_pad;

  logic                          va, vb, vc;
  logic                          ready_a, ready_b, ready_c;
  dcmp_pkg::ctl_t                ctl_a, ctl_b;
  logic [MW-1:0]                 y_a, y_b;
  logic [dcmp_pkg::PROD_W-1:0]   prod [ML][PL];
  logic [RW-1:0]                 row [ML];
  logic [RW-1:0]                 row_next [ML];
  logic [TW-1:0]                 total_next;

  assign x_pad = (LW*ML)'(x);
  assign p_pad = (LW*PL)'(power);

  assign ready_c   = !vc || out_ready;
  assign ready_b   = !vb || ready_c;
  assign ready_a   = !va || ready_b;
  assign in_ready  = ready_a;
  assign out_valid = vc;

  always_comb begin
    for (int i = 0; i < ML; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < PL; j++) begin
        row_next[i] = row_next[i] + (RW'(prod[i][j]) << (j * LW));
      end
    end
    total_next = '0;
    for (int i = 0; i < ML; i++) begin
      total_next = total_next + (TW'(row[i]) << (i * LW));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ready_a) begin
        va <= in_valid;
      end
      if (ready_b) begin
        vb <= va;
      end
      if (ready_c) begin
        vc <= vb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      ctl_a <= ctl_in;
      y_a   <= y_in;
      for (int i = 0; i < ML; i++) begin
        for (int j = 0; j < PL; j++) begin
          prod[i][j] <= x_pad[i*LW +: LW] * p_pad[j*LW +: LW];
        end
      end
    end
    if (ready_b) begin
      ctl_b <= ctl_a;
      y_b   <= y_a;
      row   <= row_next;
    end
    if (ready_c) begin
      ctl_out <= ctl_b;
      y_out   <= y_b;
      total   <= total_next;
    end
  end

endmodule

>>> src/dcmp_order.sv
// ----------------------------------------------------------------------------
// Decimal compare result stage
// Compares the scaled magnitude with the other mantissa and forms the order
// in the output register.
// ----------------------------------------------------------------------------
module dcmp_order #(
  parameter int MAX_SCALE      = dcmp_pkg::MAX_SCALE_DEF,
  parameter int MANTISSA_WIDTH = dcmp_pkg::MANTISSA_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dcmp_pkg::ctl_t            ctl,
  input  logic [MANTISSA_WIDTH-1:0] y,
  input  logic [dcmp_pkg::LIMB_W*(dcmp_pkg::limbs(MANTISSA_WIDTH)
                + dcmp_pkg::limbs(dcmp_pkg::pow10_bits(MAX_SCALE)))-1:0] total,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dcmp_pkg::order_t          order
);

  localparam int MW = MANTISSA_WIDTH;
  localparam int TW = dcmp_pkg::LIMB_W * (dcmp_pkg::limbs(MW)
                      + dcmp_pkg::limbs(dcmp_pkg::pow10_bits(MAX_SCALE)));

  logic             valid;
  logic             high_nz, x_gt, x_eq, a_gt;
  dcmp_pkg::order_t order_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    high_nz = |total[TW-1:MW];
    x_gt    = high_nz || (total[MW-1:0] > y);
    x_eq    = !high_nz && (total[MW-1:0] == y);
    // When the second operand was scaled, the sense of the magnitude test flips.
    a_gt    = ctl.swapped ? (!x_gt && !x_eq) : x_gt;
    if (ctl.early) begin
      order_next = ctl.early_order;
    end else if (x_eq) begin
      order_next = dcmp_pkg::ORDER_EQUAL;
    end else if (a_gt ^ ctl.invert) begin
      order_next = dcmp_pkg::ORDER_GREATER;
    end else begin
      order_next = dcmp_pkg::ORDER_LESS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      order <= order_next;
    end
  end

endmodule
